>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

>>> hw/rtl/salc_pkg.sv
// Shared types and codes of the set-associative LRU cache lookup unit.
// No dependencies.
`default_nettype none
package salc_pkg;
    localparam int ADDR_W = 32;

    localparam logic [1:0] EV_HIT  = 2'd0;
    localparam logic [1:0] EV_MISS = 2'd1;
    localparam logic [1:0] EV_WB   = 2'd2;

    localparam logic [1:0] TN_NONE  = 2'd0;
    localparam logic [1:0] TN_READ  = 2'd1;
    localparam logic [1:0] TN_WRITE = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    localparam logic [2:0] CFG_OFFSET_BITS    = 3'd0;
    localparam logic [2:0] CFG_SET_BITS       = 3'd1;
    localparam logic [2:0] CFG_WAYS_IN_USE    = 3'd2;
    localparam logic [2:0] CFG_WB_MODE        = 3'd3;
    localparam logic [2:0] CFG_WRITE_ALLOCATE = 3'd4;

    typedef struct packed {
        logic [1:0]        event_res;
        logic [ADDR_W-1:0] address;
        logic [1:0]        to_next;
        logic              last;
    } res_t;

    typedef struct packed {
        logic [4:0] offset_bits;
        logic [2:0] set_bits;
        logic [3:0] ways_in_use;
        logic       wb_mode;
        logic       write_allocate;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic read;
        logic eval;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_res;
    } ctrl_sts_t;
endpackage
`default_nettype wire

>>> hw/rtl/salc_req_if.sv
// Request channel: one access (load or store) per transfer.
// Depends on salc_pkg.
`default_nettype none
interface salc_req_if import salc_pkg::*;;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    modport source (output valid, output cmd, output addr, input ready);
    modport sink   (input valid, input cmd, input addr, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/salc_rsp_if.sv
// Result channel: one lookup event per transfer.
// Depends on salc_pkg.
`default_nettype none
interface salc_rsp_if import salc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [1:0]        event_res;
    logic [ADDR_W-1:0] address;
    logic [1:0]        to_next;
    logic              last;
    modport source (output valid, output event_res, output address, output to_next,
                    output last, input ready);
    modport sink   (input valid, input event_res, input address, input to_next,
                    input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/salc_ctrl.sv
// Sequencer of the lookup unit: accept, set read, evaluate, emit results.
// Depends on salc_pkg.
`default_nettype none
module salc_ctrl import salc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT);
    assign cmd.load    = in_valid && in_ready;
    assign cmd.read    = (state_reg == ST_READ);
    assign cmd.eval    = (state_reg == ST_EVAL);
    assign cmd.advance = out_valid && out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_READ;
            ST_READ: state_next = ST_EVAL;
            ST_EVAL: state_next = ST_EMIT;
            ST_EMIT: if (out_ready && sts.last_res) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

>>> hw/rtl/salc_dp.sv
// Datapath: set memory, tag compare, LRU update and result registers.
// Depends on salc_pkg.
`default_nettype none
module salc_dp import salc_pkg::*;
#(
    parameter int SETS = 64,
    parameter int WAYS = 8
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire ctrl_cmd_t         cmd,
    output ctrl_sts_t              sts,
    input  wire logic              in_cmd,
    input  wire logic [ADDR_W-1:0] in_addr,
    output res_t                   out_res
);
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int MAX_SB = $clog2(SETS + 1) - 1;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

    // set memory, one row per set
    logic [WAYS-1:0]                         vld_mem [SETS];
    logic [WAYS-1:0]                         drt_mem [SETS];
    logic [WAYS-1:0][ADDR_W-1:0]             tag_mem [SETS];
    logic [WAYS-1:0][ADDR_W-1:0]             fil_mem [SETS];
    logic [WAYS-1:0][RANK_W-1:0]             rnk_mem [SETS];
    logic [SETS-1:0]                         row_ok_reg;

    logic [WAYS-1:0]                         rd_vld_reg;
    logic [WAYS-1:0]                         rd_drt_reg;
    logic [WAYS-1:0][ADDR_W-1:0]             rd_tag_reg;
    logic [WAYS-1:0][ADDR_W-1:0]             rd_fil_reg;
    logic [WAYS-1:0][RANK_W-1:0]             rd_rnk_reg;
    logic                                    rd_ok_reg;

    logic              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    res_t              res_reg [3];
    res_t              res_next [3];
    logic [1:0]        idx_reg;

    logic [4:0]        nw;
    logic [2:0]        sb;
    logic [ADDR_W-1:0] set_full;
    logic [SET_W-1:0]  set_idx;
    logic [5:0]        shift;
    logic [ADDR_W-1:0] tag;

    logic [WAYS-1:0]             v;
    logic [WAYS-1:0]             d;
    logic [WAYS-1:0][RANK_W-1:0] rank;
    logic [WAYS-1:0]             nv;
    logic [WAYS-1:0]             nd;
    logic [WAYS-1:0][ADDR_W-1:0] ntag;
    logic [WAYS-1:0][ADDR_W-1:0] nfil;
    logic [WAYS-1:0][RANK_W-1:0] nrank;

    always_comb
    begin
        if (cfg.ways_in_use == 4'd0)
            nw = 5'd1;
        else if (32'(cfg.ways_in_use) > WAYS)
            nw = 5'(WAYS);
        else
            nw = {1'b0, cfg.ways_in_use};
        sb = (32'(cfg.set_bits) > MAX_SB) ? 3'(MAX_SB) : cfg.set_bits;
        set_full = (addr_reg >> cfg.offset_bits) & ((32'd1 << sb) - 32'd1);
        set_idx  = set_full[SET_W-1:0];
        shift    = {1'b0, cfg.offset_bits} + {3'b000, sb};
        tag      = (shift >= 6'd32) ? '0 : (addr_reg >> shift);
    end

    // lookup, replacement choice, row update and result list
    always_comb
    begin
        logic              found;
        logic              free_found;
        logic [4:0]        hit_w;
        logic [4:0]        free_w;
        logic [4:0]        vic_w;
        logic [4:0]        slot;
        logic [RANK_W-1:0] vrank;
        logic [RANK_W-1:0] old;
        logic              alloc;
        logic              wb_emit;
        logic [1:0]        n;
        found      = 1'b0;
        free_found = 1'b0;
        hit_w      = '0;
        free_w     = '0;
        vic_w      = '0;
        v    = rd_ok_reg ? rd_vld_reg : '0;
        d    = rd_ok_reg ? rd_drt_reg : '0;
        rank = rd_ok_reg ? rd_rnk_reg : '0;
        vrank = rank[0];
        for (int w = 0; w < WAYS; w++)
        begin
            if (5'(w) < nw)
            begin
                if (!found && v[w] && rd_tag_reg[w] == tag)
                begin
                    found = 1'b1;
                    hit_w = 5'(w);
                end
                if (!free_found && !v[w])
                begin
                    free_found = 1'b1;
                    free_w     = 5'(w);
                end
                if (w > 0 && rank[w] > vrank)
                begin
                    vrank = rank[w];
                    vic_w = 5'(w);
                end
            end
        end
        alloc   = !found && (cmd_reg == CMD_LOAD || cfg.write_allocate);
        slot    = found ? hit_w : (free_found ? free_w : vic_w);
        wb_emit = alloc && !free_found && d[vic_w[RANK_W-1:0]];
        old     = rank[slot[RANK_W-1:0]];

        nv    = v;
        nd    = d;
        ntag  = rd_tag_reg;
        nfil  = rd_fil_reg;
        nrank = rank;
        if (alloc)
        begin
            nv[slot[RANK_W-1:0]]   = 1'b1;
            nd[slot[RANK_W-1:0]]   = 1'b0;
            ntag[slot[RANK_W-1:0]] = tag;
            nfil[slot[RANK_W-1:0]] = addr_reg;
        end
        if (found || alloc)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (5'(w) < nw && 5'(w) != slot && v[w] &&
                    (alloc || rank[w] < old) && rank[w] < RANK_MAX)
                    nrank[w] = rank[w] + RANK_W'(1);
            end
            nrank[slot[RANK_W-1:0]] = '0;
            if (cmd_reg == CMD_STORE && cfg.wb_mode)
                nd[slot[RANK_W-1:0]] = 1'b1;
        end

        n = 2'd0;
        for (int i = 0; i < 3; i++)
            res_next[i] = '{EV_HIT, addr_reg, TN_NONE, 1'b1};
        if (wb_emit)
        begin
            res_next[n] = '{EV_WB, rd_fil_reg[vic_w[RANK_W-1:0]], TN_WRITE, 1'b0};
            n = n + 2'd1;
        end
        if (cmd_reg == CMD_LOAD)
        begin
            if (found)
                res_next[n] = '{EV_HIT, addr_reg, TN_NONE, 1'b1};
            else
                res_next[n] = '{EV_MISS, addr_reg, TN_READ, 1'b1};
        end
        else if (!found && !cfg.write_allocate)
            res_next[n] = '{EV_MISS, addr_reg, TN_WRITE, 1'b1};
        else
        begin
            if (!found)
            begin
                res_next[n] = '{EV_MISS, addr_reg, TN_READ, 1'b0};
                n = n + 2'd1;
            end
            res_next[n] = '{EV_HIT, addr_reg,
                            cfg.wb_mode ? TN_NONE : TN_WRITE, 1'b1};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_vld_reg <= vld_mem[set_idx];
            rd_drt_reg <= drt_mem[set_idx];
            rd_tag_reg <= tag_mem[set_idx];
            rd_fil_reg <= fil_mem[set_idx];
            rd_rnk_reg <= rnk_mem[set_idx];
            rd_ok_reg  <= row_ok_reg[set_idx];
        end
        if (cmd.eval)
        begin
            vld_mem[set_idx] <= nv;
            drt_mem[set_idx] <= nd;
            tag_mem[set_idx] <= ntag;
            fil_mem[set_idx] <= nfil;
            rnk_mem[set_idx] <= nrank;
            res_reg <= res_next;
        end
        if (cmd.load)
        begin
            cmd_reg  <= in_cmd;
            addr_reg <= in_addr;
        end
    end

    // a row not yet written reads as invalid, clean, rank zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ok_reg <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            if (cmd.eval)
            begin
                row_ok_reg[set_idx] <= 1'b1;
                idx_reg             <= 2'd0;
            end
            else if (cmd.advance)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    assign out_res      = res_reg[idx_reg];
    assign sts.last_res = res_reg[idx_reg].last;
endmodule
`default_nettype wire

>>> hw/rtl/set_assoc_lru_cache_lookup_unit.sv
// Top level of the set-associative LRU cache lookup unit.
// Depends on salc_pkg, salc_req_if, salc_rsp_if, salc_ctrl, salc_dp, assert_macros.svh.
// One access at a time: the accept step, a read of the set row from the set
// memory, a compare of all ways with write-back of the updated row, then one
// result per transfer (one to three). The set memory is read and written in separate
// steps, and a new access is accepted only after the last result is taken.
// Sets never written since reset read as empty; there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module set_assoc_lru_cache_lookup_unit import salc_pkg::*;
#(
    parameter int SETS = 64,
    parameter int WAYS = 8
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    salc_req_if.sink        req,
    salc_rsp_if.source      rsp,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_idx,
    input  wire logic [4:0] cfg_data
);
    cfg_t      cfg_reg;
    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    res_t      res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits    <= 5'd4;
            cfg_reg.set_bits       <= 3'd0;
            cfg_reg.ways_in_use    <= 4'd8;
            cfg_reg.wb_mode        <= 1'b1;
            cfg_reg.write_allocate <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_OFFSET_BITS:    cfg_reg.offset_bits    <= cfg_data;
                CFG_SET_BITS:       cfg_reg.set_bits       <= cfg_data[2:0];
                CFG_WAYS_IN_USE:    cfg_reg.ways_in_use    <= cfg_data[3:0];
                CFG_WB_MODE:        cfg_reg.wb_mode        <= cfg_data[0];
                CFG_WRITE_ALLOCATE: cfg_reg.write_allocate <= cfg_data[0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    salc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    salc_dp #(.SETS(SETS), .WAYS(WAYS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .sts     (sts),
        .in_cmd  (req.cmd),
        .in_addr (req.addr),
        .out_res (res)
    );

    assign rsp.event_res = res.event_res;
    assign rsp.address   = res.address;
    assign rsp.to_next   = res.to_next;
    assign rsp.last      = res.last;

    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, !req.ready)
    `ASSERT_IMPLIES(a_no_accept_while_emit, clk, rst_n, rsp.valid, !req.ready)
    `ASSERT_NEXT(a_idle_after_last, clk, rst_n, rsp.valid && rsp.ready && rsp.last, !rsp.valid)
endmodule
`default_nettype wire
